>>> rtl/core/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg - shared definitions for the cluster chain manager
// Table marks, request and status codes, sequencer states, reset contents.
// ----------------------------------------------------------------------------
package fccm_pkg;

   // default geometry
   localparam int NUM_CLUSTERS_DEF = 4096;
   localparam int FIRST_DATA_DEF   = 10;
   localparam int ROOT_CLUSTER_DEF = 9;

   // width used for compares of counts and cluster numbers
   localparam int CMP_W = 17;

   // table marks
   localparam logic [15:0] MARK_FREE = 16'h0000;
   localparam logic [15:0] MARK_END  = 16'hffff;
   localparam logic [15:0] MARK_BOOT = 16'hfffd;
   localparam logic [15:0] MARK_RSVD = 16'hfffe;

   // request codes
   localparam logic [1:0] REQ_RESIZE = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_APPEND = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_READ_WT,
      S_WALK,
      S_WALK_WT,
      S_GROW,
      S_GROW_WT,
      S_LINK,
      S_TRIM,
      S_TRIM_WT,
      S_CUT_WT,
      S_REL,
      S_REL_WT,
      S_FIN
   } state_type;

   // table contents after reset for one entry
   function automatic logic [15:0] reset_entry(int idx, int first_data, int root_cluster);
      logic [15:0] v;
      if (idx >= first_data)
         v = MARK_FREE;
      else if (idx == 0)
         v = MARK_BOOT;
      else if (idx == root_cluster)
         v = MARK_END;
      else
         v = MARK_RSVD;
      return v;
   endfunction

endpackage

>>> rtl/core/fccm_ram.sv
// ----------------------------------------------------------------------------
// fccm_ram - generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fccm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/fat_cluster_chain_manager.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager - FAT16 cluster chain allocator
// Keeps the allocation table in one RAM and serves resize, free, read-next
// and append transactions one at a time through a sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | type, first_cluster, cluster_count
//  rsp     | out       | rsp_valid/stall    | result_value, status
//
//  Every table read uses the RAM's registered read port, so each read state
//  is followed by a wait state for its data: in read-next, in the chain check
//  walk, in the scan for free clusters (with a link state per cluster linked)
//  and in trimming or releasing links.
//  After reset a clearing pass writes all NUM_CLUSTERS entries, one a cycle,
//  with req_stall high. A finished result waits in the rsp register while
//  the next transaction is accepted.
// ----------------------------------------------------------------------------
module fat_cluster_chain_manager #(
   parameter int NUM_CLUSTERS = fccm_pkg::NUM_CLUSTERS_DEF,
   parameter int FIRST_DATA   = fccm_pkg::FIRST_DATA_DEF,
   parameter int ROOT_CLUSTER = fccm_pkg::ROOT_CLUSTER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_first_cluster,
   input  logic [12:0] req_cluster_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value,
   output logic [1:0]  rsp_status
);

   localparam int AW = $clog2(NUM_CLUSTERS);
   localparam int CW = $clog2(NUM_CLUSTERS + 1);
   localparam int XW = fccm_pkg::CMP_W;
   localparam logic [XW-1:0] N_X  = XW'(NUM_CLUSTERS);
   localparam logic [XW-1:0] FD_X = XW'(FIRST_DATA);
   localparam logic [CW-1:0] FREE_INIT = CW'(NUM_CLUSTERS - FIRST_DATA);

   fccm_pkg::state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [15:0]   start_ff, start_in;
   logic [12:0]   cnt_ff, cnt_in;
   logic [15:0]   cur_ff, cur_in;
   logic [CW-1:0] len_ff, len_in;
   logic [15:0]   tail_ff, tail_in;
   logic [15:0]   head_ff, head_in;
   logic [15:0]   prev_ff, prev_in;
   logic [AW:0]   scan_ff, scan_in;
   logic [CW-1:0] need_ff, need_in;
   logic [CW-1:0] free_ff, free_in;
   logic [15:0]   value_ff, value_in;
   logic [1:0]    status_ff, status_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data;
   logic [XW-1:0] grow_diff;

   function automatic logic is_data(logic [15:0] c);
      return ({1'b0, c} >= FD_X) && ({1'b0, c} < N_X);
   endfunction

   // allocation table
   fccm_ram #(
      .WIDTH (16),
      .DEPTH (NUM_CLUSTERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign grow_diff = XW'(cnt_ff) - XW'(len_ff);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fccm_pkg::S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FREE_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_ff      <= start_in;
      cnt_ff        <= cnt_in;
      cur_ff        <= cur_in;
      len_ff        <= len_in;
      tail_ff       <= tail_in;
      head_ff       <= head_in;
      prev_ff       <= prev_in;
      scan_ff       <= scan_in;
      need_ff       <= need_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      len_in        = len_ff;
      tail_in       = tail_ff;
      head_in       = head_ff;
      prev_in       = prev_ff;
      scan_in       = scan_ff;
      need_in       = need_ff;
      free_in       = free_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff[AW-1:0];
      wr_data       = fccm_pkg::MARK_FREE;
      rd_en         = 1'b0;
      rd_addr       = cur_ff[AW-1:0];
      req_stall     = 1'b1;

      case (state_ff)
         // write reset contents, one entry a cycle
         fccm_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = fccm_pkg::reset_entry(int'(clr_ff), FIRST_DATA, ROOT_CLUSTER);
            if (clr_ff == AW'(NUM_CLUSTERS - 1)) begin
               state_in = fccm_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         fccm_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in     = req_type;
               start_in  = req_first_cluster;
               cnt_in    = req_cluster_count;
               cur_in    = req_first_cluster;
               len_in    = '0;
               tail_in   = fccm_pkg::MARK_END;
               value_in  = '0;
               status_in = fccm_pkg::ST_OK;
               state_in  = (req_type == fccm_pkg::REQ_READ) ? fccm_pkg::S_READ
                                                            : fccm_pkg::S_WALK;
            end
         end

         // read-next
         fccm_pkg::S_READ: begin
            if ({1'b0, cur_ff} < N_X) begin
               rd_en    = 1'b1;
               state_in = fccm_pkg::S_READ_WT;
            end else begin
               status_in = fccm_pkg::ST_RANGE;
               state_in  = fccm_pkg::S_FIN;
            end
         end

         fccm_pkg::S_READ_WT: begin
            value_in = rd_data;
            state_in = fccm_pkg::S_FIN;
         end

         // chain check, then dispatch
         fccm_pkg::S_WALK: begin
            if (cur_ff == fccm_pkg::MARK_END) begin
               if (op_ff == fccm_pkg::REQ_FREE) begin
                  cur_in   = start_ff;
                  state_in = fccm_pkg::S_REL;
               end else if (op_ff == fccm_pkg::REQ_APPEND ||
                            XW'(cnt_ff) > XW'(len_ff)) begin
                  if (op_ff == fccm_pkg::REQ_APPEND &&
                      XW'(cnt_ff) > XW'(free_ff)) begin
                     status_in = fccm_pkg::ST_FULL;
                     state_in  = fccm_pkg::S_FIN;
                  end else if (op_ff != fccm_pkg::REQ_APPEND &&
                               grow_diff > XW'(free_ff)) begin
                     status_in = fccm_pkg::ST_FULL;
                     state_in  = fccm_pkg::S_FIN;
                  end else begin
                     need_in  = (op_ff == fccm_pkg::REQ_APPEND) ? CW'(cnt_ff)
                                                                 : CW'(grow_diff);
                     head_in  = start_ff;
                     prev_in  = tail_ff;
                     scan_in  = (AW + 1)'(FIRST_DATA);
                     state_in = fccm_pkg::S_GROW;
                  end
               end else if (cnt_ff == '0) begin
                  cur_in   = start_ff;
                  value_in = fccm_pkg::MARK_END;
                  state_in = fccm_pkg::S_REL;
               end else begin
                  cur_in   = start_ff;
                  need_in  = CW'(cnt_ff) - 1'b1;
                  value_in = start_ff;
                  state_in = fccm_pkg::S_TRIM;
               end
            end else if (!is_data(cur_ff) || XW'(len_ff) >= N_X) begin
               status_in = fccm_pkg::ST_RANGE;
               state_in  = fccm_pkg::S_FIN;
            end else begin
               rd_en    = 1'b1;
               len_in   = len_ff + 1'b1;
               tail_in  = cur_ff;
               state_in = fccm_pkg::S_WALK_WT;
            end
         end

         fccm_pkg::S_WALK_WT: begin
            cur_in   = rd_data;
            state_in = fccm_pkg::S_WALK;
         end

         // first-free scan and linking
         fccm_pkg::S_GROW: begin
            if (need_ff == '0) begin
               value_in = head_ff;
               state_in = fccm_pkg::S_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = scan_ff[AW-1:0];
               state_in = fccm_pkg::S_GROW_WT;
            end
         end

         fccm_pkg::S_GROW_WT: begin
            if (rd_data == fccm_pkg::MARK_FREE) begin
               wr_en    = 1'b1;
               wr_addr  = scan_ff[AW-1:0];
               wr_data  = fccm_pkg::MARK_END;
               need_in  = need_ff - 1'b1;
               free_in  = free_ff - 1'b1;
               state_in = fccm_pkg::S_LINK;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = fccm_pkg::S_GROW;
            end
         end

         fccm_pkg::S_LINK: begin
            if (prev_ff == fccm_pkg::MARK_END) begin
               head_in = 16'(scan_ff);
            end else begin
               wr_en   = 1'b1;
               wr_addr = prev_ff[AW-1:0];
               wr_data = 16'(scan_ff);
            end
            prev_in  = 16'(scan_ff);
            scan_in  = scan_ff + 1'b1;
            state_in = fccm_pkg::S_GROW;
         end

         // walk to the new last cluster of a shrinking chain
         fccm_pkg::S_TRIM: begin
            rd_en    = 1'b1;
            state_in = (need_ff == '0) ? fccm_pkg::S_CUT_WT : fccm_pkg::S_TRIM_WT;
         end

         fccm_pkg::S_TRIM_WT: begin
            cur_in   = rd_data;
            need_in  = need_ff - 1'b1;
            state_in = fccm_pkg::S_TRIM;
         end

         fccm_pkg::S_CUT_WT: begin
            wr_en    = 1'b1;
            wr_data  = fccm_pkg::MARK_END;
            cur_in   = rd_data;
            state_in = fccm_pkg::S_REL;
         end

         // release a whole chain or a chain tail
         fccm_pkg::S_REL: begin
            if (cur_ff == fccm_pkg::MARK_END) begin
               state_in = fccm_pkg::S_FIN;
            end else begin
               rd_en    = 1'b1;
               state_in = fccm_pkg::S_REL_WT;
            end
         end

         fccm_pkg::S_REL_WT: begin
            wr_en    = 1'b1;
            wr_data  = fccm_pkg::MARK_FREE;
            free_in  = free_ff + 1'b1;
            cur_in   = rd_data;
            state_in = fccm_pkg::S_REL;
         end

         // hand the result to the output register
         fccm_pkg::S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_status_in = status_ff;
               state_in      = fccm_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fccm_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   // checks
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_INIT)
      else $error("free count above data cluster count");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fccm_pkg::S_FIN && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("finished transaction not presented");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == fccm_pkg::ST_OK ||
                        rsp_status_ff == fccm_pkg::ST_FULL ||
                        rsp_status_ff == fccm_pkg::ST_RANGE))
      else $error("bad status code");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fccm_pkg::S_GROW && need_ff != '0) |-> ({1'b0, scan_ff} < (AW + 2)'(NUM_CLUSTERS)))
      else $error("free scan ran past the table");

endmodule
